// ===== sv/fpb_pkg.sv =====
// Shared types and constants for the floating-point power-by-squaring block.
package fpb_pkg;

    localparam int EXP_WIDTH = 32;
    localparam int CNT_W     = $clog2(EXP_WIDTH);

    localparam logic [63:0] ONE_BITS       = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN    = 64'hFFF8_0000_0000_0000;
    localparam logic [62:0] NEAR_ZERO_MAG  = 63'h3E45_798E_E230_8C3A;
    localparam logic [10:0] EXP_ALL_ONES   = 11'h7FF;

    typedef enum logic [2:0] {
        T_IDLE,
        T_SCAN,
        T_NEXT,
        T_WAIT_SQ,
        T_MULX,
        T_WAIT_MX,
        T_WAIT_DIV,
        T_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_NORM,
        F_MUL,
        F_DIV,
        F_ALIGN,
        F_ROUND,
        F_DONE
    } fpu_state_t;

    typedef enum logic {
        OP_MUL,
        OP_RECIP
    } fpu_op_t;

    typedef struct packed {
        logic    start;
        fpu_op_t op;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } fpu_rsp_t;

endpackage

// ===== sv/fpb_fpu.sv =====
// Iterative binary64 multiply and reciprocal unit with round-to-nearest-even.
module fpb_fpu
    import fpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fpu_req_t    req,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output fpu_rsp_t    rsp
);

    fpu_state_t         state_reg, state_next;
    fpu_op_t            op_reg, op_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               sign_reg, sign_next;
    logic [52:0]        ma_reg, ma_next;
    logic [52:0]        mb_reg, mb_next;
    logic signed [13:0] ea_reg, ea_next;
    logic signed [13:0] eb_reg, eb_next;
    logic signed [13:0] exp_reg, exp_next;
    logic [105:0]       w_reg, w_next;
    logic [53:0]        rem_reg, rem_next;
    logic               sticky_reg, sticky_next;
    logic [63:0]        res_reg, res_next;

    logic [10:0]  a_exp, b_exp;
    logic [51:0]  a_frac, b_frac;
    logic         a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [26:0]  mul_x, mul_y;
    logic [53:0]  pp;
    logic [6:0]   pp_shift;
    logic         ge;
    logic [53:0]  diff;
    logic signed [13:0] under;
    logic [6:0]   rsh;
    logic [105:0] shifted, lost_mask;
    logic [52:0]  m;
    logic         g, s, up;
    logic [53:0]  mr;
    logic [10:0]  base_exp;
    logic [62:0]  mag;

    assign a_exp  = a[62:52];
    assign b_exp  = b[62:52];
    assign a_frac = a[51:0];
    assign b_frac = b[51:0];
    assign a_nan  = (a_exp == EXP_ALL_ONES) && (a_frac != '0);
    assign b_nan  = (b_exp == EXP_ALL_ONES) && (b_frac != '0);
    assign a_inf  = (a_exp == EXP_ALL_ONES) && (a_frac == '0);
    assign b_inf  = (b_exp == EXP_ALL_ONES) && (b_frac == '0);
    assign a_zero = (a[62:0] == '0);
    assign b_zero = (b[62:0] == '0);

    // The 53x53 significand product is built from four 27x27 partial products.
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                mul_x    = ma_reg[26:0];
                mul_y    = mb_reg[26:0];
                pp_shift = 7'd0;
            end
            2'd1:
            begin
                mul_x    = ma_reg[26:0];
                mul_y    = {1'b0, mb_reg[52:27]};
                pp_shift = 7'd27;
            end
            2'd2:
            begin
                mul_x    = {1'b0, ma_reg[52:27]};
                mul_y    = mb_reg[26:0];
                pp_shift = 7'd27;
            end
            default:
            begin
                mul_x    = {1'b0, ma_reg[52:27]};
                mul_y    = {1'b0, mb_reg[52:27]};
                pp_shift = 7'd54;
            end
        endcase
    end

    assign pp   = mul_x * mul_y;
    assign ge   = (rem_reg >= {1'b0, mb_reg});
    assign diff = ge ? (rem_reg - {1'b0, mb_reg}) : rem_reg;

    // Rounding: results below the normal range are shifted right first.
    always_comb
    begin
        under = 14'sd1 - exp_reg;
        if (exp_reg >= 14'sd1)
        begin
            rsh = 7'd0;
        end
        else if (under > 14'sd127)
        begin
            rsh = 7'd127;
        end
        else
        begin
            rsh = under[6:0];
        end
        shifted   = w_reg >> rsh;
        lost_mask = ~({106{1'b1}} << rsh);
        m         = shifted[105:53];
        g         = shifted[52];
        s         = (shifted[51:0] != '0) || ((w_reg & lost_mask) != '0) || sticky_reg;
        up        = g && (s || m[0]);
        mr        = {1'b0, m} + {53'b0, up};
        base_exp  = (exp_reg >= 14'sd1) ? exp_reg[10:0] - 11'd1 : 11'd0;
        mag       = {base_exp, 52'b0} + {9'b0, mr};
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        sign_next   = sign_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        ea_next     = ea_reg;
        eb_next     = eb_reg;
        exp_next    = exp_reg;
        w_next      = w_reg;
        rem_next    = rem_reg;
        sticky_next = sticky_reg;
        res_next    = res_reg;
        rsp.done    = 1'b0;
        rsp.result  = res_reg;

        case (state_reg)
            F_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    state_next = F_NORM;
                    ma_next    = {(a_exp != '0), a_frac};
                    ea_next    = (a_exp == '0) ? 14'sd1 : $signed({3'b0, a_exp});
                    mb_next    = {(b_exp != '0), b_frac};
                    eb_next    = (b_exp == '0) ? 14'sd1 : $signed({3'b0, b_exp});
                    if (req.op == OP_MUL)
                    begin
                        sign_next = a[63] ^ b[63];
                        if (a_nan)
                        begin
                            res_next   = {a[63:52], 1'b1, a[50:0]};
                            state_next = F_DONE;
                        end
                        else if (b_nan)
                        begin
                            res_next   = {b[63:52], 1'b1, b[50:0]};
                            state_next = F_DONE;
                        end
                        else if ((a_inf && b_zero) || (a_zero && b_inf))
                        begin
                            res_next   = DEFAULT_NAN;
                            state_next = F_DONE;
                        end
                        else if (a_inf || b_inf)
                        begin
                            res_next   = {a[63] ^ b[63], EXP_ALL_ONES, 52'b0};
                            state_next = F_DONE;
                        end
                        else if (a_zero || b_zero)
                        begin
                            res_next   = {a[63] ^ b[63], 63'b0};
                            state_next = F_DONE;
                        end
                    end
                    else
                    begin
                        // The dividend is the constant one.
                        sign_next = b[63];
                        ma_next   = {1'b1, 52'b0};
                        ea_next   = 14'sd1023;
                        if (b_nan)
                        begin
                            res_next   = {b[63:52], 1'b1, b[50:0]};
                            state_next = F_DONE;
                        end
                        else if (b_inf)
                        begin
                            res_next   = {b[63], 63'b0};
                            state_next = F_DONE;
                        end
                        else if (b_zero)
                        begin
                            res_next   = {b[63], EXP_ALL_ONES, 52'b0};
                            state_next = F_DONE;
                        end
                    end
                end
            end
            F_NORM:
            begin
                if (!ma_reg[52])
                begin
                    ma_next = {ma_reg[51:0], 1'b0};
                    ea_next = ea_reg - 14'sd1;
                end
                else if (!mb_reg[52])
                begin
                    mb_next = {mb_reg[51:0], 1'b0};
                    eb_next = eb_reg - 14'sd1;
                end
                else
                begin
                    cnt_next = '0;
                    w_next   = '0;
                    rem_next = {2'b01, 52'b0};
                    state_next = (op_reg == OP_MUL) ? F_MUL : F_DIV;
                end
            end
            F_MUL:
            begin
                w_next   = w_reg + ({52'b0, pp} << pp_shift);
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[1:0] == 2'd3)
                begin
                    exp_next    = ea_reg + eb_reg - 14'sd1022;
                    sticky_next = 1'b0;
                    state_next  = F_ALIGN;
                end
            end
            F_DIV:
            begin
                rem_next = {diff[52:0], 1'b0};
                w_next   = {w_reg[104:0], ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd55)
                begin
                    w_next      = {w_reg[54:0], ge, 50'b0};
                    sticky_next = (diff != '0);
                    exp_next    = 14'sd2046 - eb_reg;
                    state_next  = F_ALIGN;
                end
            end
            F_ALIGN:
            begin
                if (!w_reg[105])
                begin
                    w_next   = {w_reg[104:0], 1'b0};
                    exp_next = exp_reg - 14'sd1;
                end
                state_next = F_ROUND;
            end
            F_ROUND:
            begin
                if (exp_reg >= 14'sd2047)
                begin
                    res_next = {sign_reg, EXP_ALL_ONES, 52'b0};
                end
                else
                begin
                    res_next = {sign_reg, mag};
                end
                state_next = F_DONE;
            end
            F_DONE:
            begin
                rsp.done   = 1'b1;
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        sign_reg   <= sign_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        ea_reg     <= ea_next;
        eb_reg     <= eb_next;
        exp_reg    <= exp_next;
        w_reg      <= w_next;
        rem_reg    <= rem_next;
        sticky_reg <= sticky_next;
        res_reg    <= res_next;
    end

endmodule

// ===== sv/float_power_by_squaring_top.sv =====
// Top level: square-and-multiply sequencer around the shared floating-point unit.
//
//   channel | signals                                  | direction
//   input   | in_valid, in_ready, base, exponent       | into block
//   output  | out_valid, out_ready, power, invalid_now,| out of block
//           | invalid_seen                             |
//
// One item at a time: in_ready is high only while the sequencer is idle.
// An item first scans past the leading zero bits of |exponent|, then runs the
// squarings and multiplies (up to 60), plus a reciprocal for a negative exponent.
// Each squaring or multiply is issued by the sequencer, then the arithmetic unit
// runs normalize, four passes of the 27x27 multiplier, align, round and hand back.
// Subnormal operands add one normalizing shift per leading zero bit.
// Reset is asynchronous and clears the sequencer and the sticky invalid flag.
// A held result stalls the block until out_ready takes it.
module float_power_by_squaring_top
    import fpb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] base,
    input  logic [31:0] exponent,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] power,
    output logic        invalid_now,
    output logic        invalid_seen
);

    top_state_t           state_reg, state_next;
    logic [63:0]          x_reg, x_next;
    logic [63:0]          r_reg, r_next;
    logic [EXP_WIDTH-1:0] mag_reg, mag_next;
    logic [CNT_W-1:0]     left_reg, left_next;
    logic                 neg_reg, neg_next;
    logic [63:0]          power_reg, power_next;
    logic                 inv_now_reg, inv_now_next;
    logic                 sticky_reg, sticky_next;

    logic [EXP_WIDTH-1:0] e_in, e_mag;
    logic                 e_neg, near_zero;
    fpu_req_t             fpu_req;
    fpu_rsp_t             fpu_rsp;
    logic [63:0]          fpu_a, fpu_b;

    assign e_in  = exponent[EXP_WIDTH-1:0];
    assign e_neg = e_in[EXP_WIDTH-1];
    assign e_mag = e_neg ? (~e_in + 1'b1) : e_in;
    // NaN counts as near zero.
    assign near_zero = ((base[62:52] == EXP_ALL_ONES) && (base[51:0] != '0))
                       || (base[62:0] <= NEAR_ZERO_MAG);

    fpb_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fpu_req),
        .a     (fpu_a),
        .b     (fpu_b),
        .rsp   (fpu_rsp)
    );

    always_comb
    begin
        state_next   = state_reg;
        x_next       = x_reg;
        r_next       = r_reg;
        mag_next     = mag_reg;
        left_next    = left_reg;
        neg_next     = neg_reg;
        power_next   = power_reg;
        inv_now_next = inv_now_reg;
        sticky_next  = sticky_reg;
        fpu_req.start = 1'b0;
        fpu_req.op    = OP_MUL;
        fpu_a         = r_reg;
        fpu_b         = r_reg;

        case (state_reg)
            T_IDLE:
            begin
                if (in_valid)
                begin
                    x_next       = base;
                    mag_next     = e_mag;
                    neg_next     = e_neg;
                    left_next    = CNT_W'(EXP_WIDTH - 1);
                    inv_now_next = 1'b0;
                    if (e_neg && near_zero)
                    begin
                        power_next   = '0;
                        inv_now_next = 1'b1;
                        sticky_next  = 1'b1;
                        state_next   = T_OUT;
                    end
                    else if (e_mag == '0)
                    begin
                        power_next = ONE_BITS;
                        state_next = T_OUT;
                    end
                    else
                    begin
                        state_next = T_SCAN;
                    end
                end
            end
            T_SCAN:
            begin
                if (mag_reg[EXP_WIDTH-1])
                begin
                    r_next     = x_reg;
                    state_next = T_NEXT;
                end
                else
                begin
                    mag_next  = {mag_reg[EXP_WIDTH-2:0], 1'b0};
                    left_next = left_reg - 1'b1;
                end
            end
            T_NEXT:
            begin
                if (left_reg == '0)
                begin
                    if (neg_reg)
                    begin
                        fpu_req.start = 1'b1;
                        fpu_req.op    = OP_RECIP;
                        state_next    = T_WAIT_DIV;
                    end
                    else
                    begin
                        power_next = r_reg;
                        state_next = T_OUT;
                    end
                end
                else
                begin
                    mag_next      = {mag_reg[EXP_WIDTH-2:0], 1'b0};
                    left_next     = left_reg - 1'b1;
                    fpu_req.start = 1'b1;
                    state_next    = T_WAIT_SQ;
                end
            end
            T_WAIT_SQ:
            begin
                if (fpu_rsp.done)
                begin
                    r_next = fpu_rsp.result;
                    if (mag_reg[EXP_WIDTH-1])
                    begin
                        state_next = T_MULX;
                    end
                    else
                    begin
                        state_next = T_NEXT;
                    end
                end
            end
            T_MULX:
            begin
                // The unit is back in idle here and takes the multiply by the base.
                fpu_a         = r_reg;
                fpu_b         = x_reg;
                fpu_req.start = 1'b1;
                state_next    = T_WAIT_MX;
            end
            T_WAIT_MX:
            begin
                if (fpu_rsp.done)
                begin
                    r_next     = fpu_rsp.result;
                    state_next = T_NEXT;
                end
            end
            T_WAIT_DIV:
            begin
                if (fpu_rsp.done)
                begin
                    power_next = fpu_rsp.result;
                    state_next = T_OUT;
                end
            end
            T_OUT:
            begin
                if (out_ready)
                begin
                    state_next = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_IDLE;
            sticky_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sticky_reg <= sticky_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        r_reg       <= r_next;
        mag_reg     <= mag_next;
        left_reg    <= left_next;
        neg_reg     <= neg_next;
        power_reg   <= power_next;
        inv_now_reg <= inv_now_next;
    end

    assign in_ready     = (state_reg == T_IDLE);
    assign out_valid    = (state_reg == T_OUT);
    assign power        = power_reg;
    assign invalid_now  = inv_now_reg;
    assign invalid_seen = sticky_reg;

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides active together");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && invalid_now) |-> (power == '0 && invalid_seen))
        else $error("invalid item without zero power or sticky flag");

    a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(invalid_seen))
        else $error("sticky invalid flag cleared");

    a_fpu_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        fpu_rsp.done |-> (state_reg == T_WAIT_SQ || state_reg == T_WAIT_MX
                          || state_reg == T_WAIT_DIV))
        else $error("arithmetic result with no operation pending");
`endif

endmodule
